FILE: design/hidnorm_pkg.sv
// shared types, codes and lookup functions for the hid axis value normalizer
package hidnorm_pkg;

   localparam int RAW_W   = 32;
   localparam int BITS_W  = 6;
   localparam int LEVEL_W = 17;
   localparam int MASK_W  = 4;
   localparam int NUM_W   = 35;
   localparam int DEN_W   = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   localparam logic [DEN_W-1:0] FALLBACK_RANGE = 32'h0000_FFFF;

   // action codes
   localparam logic [1:0] ACT_STICK   = 2'd0;
   localparam logic [1:0] ACT_TRIGGER = 2'd1;
   localparam logic [1:0] ACT_HAT     = 2'd2;

   // d-pad direction bits
   localparam logic [MASK_W-1:0] DIR_UP    = 4'b0001;
   localparam logic [MASK_W-1:0] DIR_DOWN  = 4'b0010;
   localparam logic [MASK_W-1:0] DIR_LEFT  = 4'b0100;
   localparam logic [MASK_W-1:0] DIR_RIGHT = 4'b1000;

   typedef enum logic [1:0] {
      OP_STICK,
      OP_TRIGGER,
      OP_FIXED
   } op_type;

   typedef struct packed {
      logic [1:0]               action;
      logic [RAW_W-1:0]         raw_value;
      logic signed [RAW_W-1:0]  logical_min;
      logic signed [RAW_W-1:0]  logical_max;
      logic [BITS_W-1:0]        field_bits;
   } req_type;

   typedef struct packed {
      logic signed [LEVEL_W-1:0] level;
      logic [MASK_W-1:0]         dpad_mask;
   } rsp_type;

   typedef struct packed {
      op_type                  op;
      logic signed [NUM_W-1:0] num;
      logic [DEN_W-1:0]        den;
      logic [MASK_W-1:0]       mask;
   } work_type;

   function automatic logic [MASK_W-1:0] hat8_mask(input logic [2:0] pos);
      logic [MASK_W-1:0] m;
      case (pos)
         3'd0:    m = DIR_UP;
         3'd1:    m = DIR_UP | DIR_RIGHT;
         3'd2:    m = DIR_RIGHT;
         3'd3:    m = DIR_DOWN | DIR_RIGHT;
         3'd4:    m = DIR_DOWN;
         3'd5:    m = DIR_DOWN | DIR_LEFT;
         3'd6:    m = DIR_LEFT;
         default: m = DIR_UP | DIR_LEFT;
      endcase
      return m;
   endfunction

   function automatic logic [MASK_W-1:0] hat4_mask(input logic [1:0] pos);
      logic [MASK_W-1:0] m;
      case (pos)
         2'd0:    m = DIR_UP;
         2'd1:    m = DIR_RIGHT;
         2'd2:    m = DIR_DOWN;
         default: m = DIR_LEFT;
      endcase
      return m;
   endfunction

endpackage

FILE: design/hidnorm_front.sv
// front end: interprets the raw field and forms numerator, range and hat mask
module hidnorm_front import hidnorm_pkg::*; (
   input  req_type  req,
   output work_type work
);

   logic                    bits_ok;
   logic [DEN_W-1:0]        low_mask;
   logic [DEN_W-1:0]        fb_range;
   logic                    sign_bit;
   logic [RAW_W-1:0]        ext_raw;
   logic signed [RAW_W-1:0] val;
   logic signed [NUM_W-1:0] val_x;
   logic signed [NUM_W-1:0] lo_x;
   logic signed [NUM_W-1:0] hi_x;
   logic signed [NUM_W-1:0] span_x;
   logic signed [NUM_W-1:0] fb_num;
   logic signed [NUM_W-1:0] stick_num;
   logic signed [NUM_W-1:0] trig_num;
   logic                    range_ok;
   logic signed [RAW_W-1:0] hat_val;
   logic                    hat_in;
   logic [2:0]              hat_pos;
   logic [MASK_W-1:0]       hat_mask;

   always_comb begin
      bits_ok  = req.field_bits inside {[6'd1:6'd31]};
      low_mask = (32'd1 << req.field_bits[4:0]) - 32'd1;
      fb_range = bits_ok ? low_mask : FALLBACK_RANGE;

      // sign extension from the descriptor width (top bit of low_mask is the sign)
      sign_bit = |(req.raw_value & (low_mask ^ (low_mask >> 1)));
      ext_raw  = sign_bit ? (req.raw_value | ~low_mask) : (req.raw_value & low_mask);
      val      = (req.logical_min < 0 && bits_ok) ? $signed(ext_raw)
                                                  : $signed(req.raw_value);

      val_x  = NUM_W'(val);
      lo_x   = NUM_W'(req.logical_min);
      hi_x   = NUM_W'(req.logical_max);
      span_x = hi_x - lo_x;

      range_ok  = req.logical_min < req.logical_max;
      stick_num = (val_x <<< 1) - lo_x - hi_x;
      trig_num  = val_x - lo_x;
      fb_num    = $signed({2'b00, req.raw_value, 1'b0}) - $signed({3'b000, fb_range});

      // hat switch: position is raw - min, valid only inside the logical range
      hat_val  = $signed(req.raw_value);
      hat_in   = hat_val >= req.logical_min && hat_val <= req.logical_max;
      hat_pos  = req.raw_value[2:0] - req.logical_min[2:0];
      hat_mask = '0;
      if (hat_in) begin
         if (span_x == NUM_W'(7)) begin
            hat_mask = hat8_mask(hat_pos);
         end else if (span_x == NUM_W'(3)) begin
            hat_mask = hat4_mask(hat_pos[1:0]);
         end
      end

      work.num  = fb_num;
      work.den  = range_ok ? span_x[DEN_W-1:0] : fb_range;
      work.mask = '0;
      case (req.action)
         ACT_STICK: begin
            work.op = OP_STICK;
            if (range_ok) begin
               work.num = stick_num;
            end
         end
         ACT_TRIGGER: begin
            work.op = OP_TRIGGER;
            if (range_ok) begin
               work.num = trig_num;
            end
         end
         ACT_HAT: begin
            work.op   = OP_FIXED;
            work.mask = hat_mask;
         end
         default: begin
            work.op = OP_FIXED;
         end
      endcase
   end

endmodule

FILE: design/hidnorm_queue.sv
// short fifo that decouples the front end from the divider pipeline
module hidnorm_queue import hidnorm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  work_type wr_data,
   output logic     full,
   input  logic     rd_en,
   output work_type rd_data,
   output logic     empty
);

   work_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                    do_wr, do_rd;

   always_comb begin
      full      = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
      empty     = count_ff == '0;
      do_wr     = wr_en && !full;
      do_rd     = rd_en && !empty;
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(do_wr) - QUEUE_CNT_W'(do_rd);
      rd_data   = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: design/hidnorm_back.sv
// back end: saturation decision, one-bit-per-stage divider and result register
module hidnorm_back import hidnorm_pkg::*; #(
   parameter int FRACTION_BITS = 15
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  work_type in_data,
   output logic     in_take,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_data
);

   localparam int LW = FRACTION_BITS + 2;
   localparam int NS = FRACTION_BITS + 1;
   localparam logic signed [LW-1:0] LEVEL_ONE = LW'(64'd1 << FRACTION_BITS);

   logic                       adv;
   logic                       valid_ff [NS];
   logic                       byp_ff   [NS];
   logic signed [LW-1:0]       fix_ff   [NS];
   logic [DEN_W-1:0]           rem_ff   [NS];
   logic [DEN_W-1:0]           den_ff   [NS];
   logic [FRACTION_BITS-1:0]   quo_ff   [NS];
   logic                       neg_ff   [NS];
   logic [MASK_W-1:0]          mask_ff  [NS];

   logic                       byp_in;
   logic signed [LW-1:0]       fix_in;
   logic [DEN_W-1:0]           rem_in;
   logic                       neg_in;
   logic signed [NUM_W-1:0]    den_x;
   logic signed [NUM_W-1:0]    abs_num;

   logic                       out_valid_ff, out_valid_in;
   rsp_type                    out_data_ff, out_data_in;
   logic signed [LW-1:0]       quo_x;
   logic signed [LW-1:0]       lvl;

   assign adv     = !out_valid_ff || rsp_pop;
   assign in_take = adv && in_valid;

   // stage 0: saturate at range, 0 for fixed ops and negative triggers, else divide
   always_comb begin
      den_x   = $signed({3'b000, in_data.den});
      abs_num = in_data.num[NUM_W-1] ? -in_data.num : in_data.num;
      neg_in  = in_data.num[NUM_W-1];
      rem_in  = abs_num[DEN_W-1:0];
      byp_in  = 1'b1;
      fix_in  = '0;
      if (in_data.op != OP_FIXED) begin
         if (in_data.num >= den_x) begin
            fix_in = LEVEL_ONE;
         end else if (in_data.num + den_x <= 0) begin
            fix_in = (in_data.op == OP_STICK) ? -LEVEL_ONE : '0;
         end else if (neg_in && in_data.op == OP_TRIGGER) begin
            fix_in = '0;
         end else begin
            byp_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         byp_ff[0]  <= byp_in;
         fix_ff[0]  <= fix_in;
         rem_ff[0]  <= rem_in;
         den_ff[0]  <= in_data.den;
         quo_ff[0]  <= '0;
         neg_ff[0]  <= neg_in;
         mask_ff[0] <= in_data.mask;
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar k = 1; k < NS; k++) begin : g_div
      logic [DEN_W:0]   dbl;
      logic             ge;
      logic [DEN_W-1:0] rem_next;

      always_comb begin
         dbl      = {rem_ff[k-1], 1'b0};
         ge       = dbl >= {1'b0, den_ff[k-1]};
         rem_next = ge ? DEN_W'(dbl - {1'b0, den_ff[k-1]}) : dbl[DEN_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            byp_ff[k]  <= byp_ff[k-1];
            fix_ff[k]  <= fix_ff[k-1];
            rem_ff[k]  <= rem_next;
            den_ff[k]  <= den_ff[k-1];
            quo_ff[k]  <= {quo_ff[k-1][FRACTION_BITS-2:0], ge};
            neg_ff[k]  <= neg_ff[k-1];
            mask_ff[k] <= mask_ff[k-1];
         end
      end
   end

   always_comb begin
      quo_x = $signed({2'b00, quo_ff[NS-1]});
      lvl   = byp_ff[NS-1] ? fix_ff[NS-1] : (neg_ff[NS-1] ? -quo_x : quo_x);
      out_data_in.level     = LEVEL_W'(lvl);
      out_data_in.dpad_mask = mask_ff[NS-1];
      out_valid_in = adv ? valid_ff[NS-1] : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

FILE: design/hid_axis_value_normalizer.sv
// hid axis value normalizer: top level joining front end, queue and divider pipeline
//
// One HID value field enters per beat (push while full is low) and one result
// leaves per beat (pop while empty is low), in order. Stick action maps the
// logical range onto [-1,1], trigger onto [0,1], with 1.0 = 2^FRACTION_BITS,
// truncated toward zero and saturated; when min is not below max the range
// falls back to 2^field_bits-1 (or 65535). Hat action gives a d-pad mask for
// 8- and 4-position switches. The block sustains one beat per cycle in both
// directions while the output side keeps up; each result passes through the
// queue, the divider pipeline that produces one quotient bit per stage and
// the result register. A four-entry queue sits between the classifying front
// end and the pipeline, so a stalled output side backs up the pipeline first
// and raises full only once the queue has filled.
module hid_axis_value_normalizer import hidnorm_pkg::*; #(
   parameter int FRACTION_BITS = 15
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   work_type front_work;
   work_type queue_head;
   logic     queue_empty;
   logic     back_take;

   // front end: classify action, interpret raw value, build numerator and range
   hidnorm_front u_front (
      .req  (req_data),
      .work (front_work)
   );

   // decoupling queue; its full flag is the input side's full
   hidnorm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (front_work),
      .full    (full),
      .rd_en   (back_take),
      .rd_data (queue_head),
      .empty   (queue_empty)
   );

   // back end: saturation, pipelined division and result register
   hidnorm_back #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!queue_empty),
      .in_data   (queue_head),
      .in_take   (back_take),
      .rsp_empty (empty),
      .rsp_pop   (pop),
      .rsp_data  (rsp_data)
   );

   // nothing to deliver right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result pending after reset");

   // a nonzero level only comes from stick or trigger, which carry no d-pad bits
   a_level_no_mask: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.level != '0 |-> rsp_data.dpad_mask == '0)
      else $error("level and d-pad mask both set");

   // a hat never points in two opposite directions
   a_no_opposite: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !(rsp_data.dpad_mask[0] && rsp_data.dpad_mask[1]) &&
                 !(rsp_data.dpad_mask[2] && rsp_data.dpad_mask[3]))
      else $error("opposite d-pad directions");

endmodule
